// ===== design/bba_pkg.sv =====
// shared types and codes for the buddy block allocator
// used by the controller, datapath and top level; no dependencies
package bba_pkg;

  localparam logic OPC_ALLOC = 1'b0;
  localparam logic OPC_FREE  = 1'b1;

  localparam logic REG_POOL_ORDER = 1'b0;
  localparam logic REG_BASE       = 1'b1;

  localparam int unsigned WORD_BITS = 32;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR,
    OP_CAP,
    OP_CALC1,
    OP_CALC2,
    OP_RD_W,
    OP_A_CHK,
    OP_SP_RD,
    OP_SP_WR,
    OP_RD_G,
    OP_F_CHK,
    OP_M_INIT,
    OP_RD_B,
    OP_B_CHK,
    OP_RD_H,
    OP_SET_H,
    OP_OUT_OK,
    OP_OUT_FAIL,
    OP_OUT_FREE
  } op_e;

  typedef struct packed {
    logic clr_last;
    logic bad;
    logic is_free;
    logic found;
    logic word_last;
    logic o_last;
    logic o_eq_k;
    logic g_bit;
    logic b_bit;
    logic out_full;
    logic pool_wr;
  } stat_t;

endpackage

// ===== design/bba_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module bba_ram #(
  parameter int unsigned W = 32,
  parameter int unsigned D = 64
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr_i,
  input  logic [W-1:0]                    wdata_i,
  input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr_i,
  output logic [W-1:0]                    rdata_o
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/bba_ctrl.sv =====
// sequencing state machine of the buddy block allocator
// depends on bba_pkg
module bba_ctrl
  import bba_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  stat_t stat_i,
  output op_e   op_o,
  output logic  ready_o
);

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_C1       = 5'd2;
  localparam logic [4:0] S_C2       = 5'd3;
  localparam logic [4:0] S_DISP     = 5'd4;
  localparam logic [4:0] S_A_RD     = 5'd5;
  localparam logic [4:0] S_A_CHK    = 5'd6;
  localparam logic [4:0] S_SP_RD    = 5'd7;
  localparam logic [4:0] S_SP_WR    = 5'd8;
  localparam logic [4:0] S_F_RD     = 5'd9;
  localparam logic [4:0] S_F_CHK    = 5'd10;
  localparam logic [4:0] S_M_TOP    = 5'd11;
  localparam logic [4:0] S_M        = 5'd12;
  localparam logic [4:0] S_B_RD     = 5'd13;
  localparam logic [4:0] S_B_CHK    = 5'd14;
  localparam logic [4:0] S_S_RD     = 5'd15;
  localparam logic [4:0] S_S_WR     = 5'd16;
  localparam logic [4:0] S_OUT_OK   = 5'd17;
  localparam logic [4:0] S_OUT_FAIL = 5'd18;
  localparam logic [4:0] S_OUT_FREE = 5'd19;

  logic [4:0] state_q, state_d;

  assign ready_o = (state_q == S_IDLE) && !stat_i.pool_wr;

  always_comb begin
    state_d = state_q;
    op_o    = OP_NONE;
    unique case (state_q)
      S_CLR: begin
        op_o = OP_CLR;
        if (stat_i.clr_last && !stat_i.pool_wr) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (stat_i.pool_wr) begin
          state_d = S_CLR;
        end else if (in_valid_i) begin
          op_o    = OP_CAP;
          state_d = S_C1;
        end
      end
      S_C1: begin
        op_o    = OP_CALC1;
        state_d = S_C2;
      end
      S_C2: begin
        op_o    = OP_CALC2;
        state_d = S_DISP;
      end
      S_DISP: begin
        if (stat_i.bad) state_d = stat_i.is_free ? S_OUT_FREE : S_OUT_FAIL;
        else            state_d = stat_i.is_free ? S_F_RD : S_A_RD;
      end
      S_A_RD: begin
        op_o    = OP_RD_W;
        state_d = S_A_CHK;
      end
      S_A_CHK: begin
        op_o = OP_A_CHK;
        if (stat_i.found)                              state_d = stat_i.o_eq_k ? S_OUT_OK : S_SP_RD;
        else if (stat_i.word_last && stat_i.o_last)    state_d = S_OUT_FAIL;
        else                                           state_d = S_A_RD;
      end
      S_SP_RD: begin
        op_o    = OP_SP_RD;
        state_d = S_SP_WR;
      end
      S_SP_WR: begin
        op_o    = OP_SP_WR;
        state_d = stat_i.o_eq_k ? S_OUT_OK : S_SP_RD;
      end
      S_F_RD: begin
        op_o    = OP_RD_G;
        state_d = S_F_CHK;
      end
      S_F_CHK: begin
        op_o = OP_F_CHK;
        if (stat_i.g_bit)       state_d = S_OUT_FREE;
        else if (stat_i.o_last) state_d = S_M_TOP;
        else                    state_d = S_F_RD;
      end
      S_M_TOP: begin
        op_o    = OP_M_INIT;
        state_d = S_M;
      end
      S_M: begin
        state_d = stat_i.o_last ? S_S_RD : S_B_RD;
      end
      S_B_RD: begin
        op_o    = OP_RD_B;
        state_d = S_B_CHK;
      end
      S_B_CHK: begin
        op_o    = OP_B_CHK;
        state_d = stat_i.b_bit ? S_M : S_S_RD;
      end
      S_S_RD: begin
        op_o    = OP_RD_H;
        state_d = S_S_WR;
      end
      S_S_WR: begin
        op_o    = OP_SET_H;
        state_d = S_OUT_FREE;
      end
      S_OUT_OK: begin
        if (!stat_i.out_full) begin
          op_o    = OP_OUT_OK;
          state_d = S_IDLE;
        end
      end
      S_OUT_FAIL: begin
        if (!stat_i.out_full) begin
          op_o    = OP_OUT_FAIL;
          state_d = S_IDLE;
        end
      end
      S_OUT_FREE: begin
        if (!stat_i.out_full) begin
          op_o    = OP_OUT_FREE;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_CLR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/bba_dp.sv =====
// datapath of the buddy block allocator: request, order and tree index registers
// depends on bba_pkg; drives the free map ram ports
module bba_dp
  import bba_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 10,
  parameter int unsigned MIN_BLOCK = 1024,
  localparam int unsigned HW  = (MAX_ORDER + 1 > 5) ? MAX_ORDER + 1 : 5,
  localparam int unsigned NW  = (MAX_ORDER + 1 > 5) ? (1 << (MAX_ORDER - 4)) : 1,
  localparam int unsigned AW  = (NW > 1) ? $clog2(NW) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  op_e                  op_i,
  output stat_t                stat_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [31:0]          cfg_data_i,
  input  logic                 opcode_i,
  input  logic [20:0]          request_size_i,
  input  logic [31:0]          user_address_i,
  input  logic                 out_stall_i,
  output logic                 out_valid_o,
  output logic                 status_o,
  output logic [31:0]          result_address_o,
  output logic                 ram_we_o,
  output logic [AW-1:0]        ram_waddr_o,
  output logic [WORD_BITS-1:0] ram_wdata_o,
  output logic [AW-1:0]        ram_raddr_o,
  input  logic [WORD_BITS-1:0] ram_rdata_i
);

  localparam int unsigned IX    = AW + 5;
  localparam int unsigned OW    = $clog2(MAX_ORDER + 2);
  localparam int unsigned LOGMB = $clog2(MIN_BLOCK);

  function automatic logic [AW-1:0] word_of(input logic [IX-1:0] idx);
    logic [IX-1:0] t;
    t = idx >> 5;
    return t[AW-1:0];
  endfunction

  logic [3:0]    pool_q;
  logic [31:0]   base_q;
  logic          opc_q;
  logic [20:0]   size_q;
  logic [31:0]   user_q;
  logic [OW-1:0] p_q, p_d, k_q, k_d, o_q, o_d;
  logic          bad_q, bad_d;
  logic [AW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d, g_q, g_d;
  logic          out_valid_q, out_valid_d;
  logic          out_status_q, out_status_d;
  logic [31:0]   out_addr_q, out_addr_d;

  logic [OW-1:0] p_eff;
  logic [HW-1:0] root;
  logic [21:0]   need;
  logic [OW-1:0] kk;
  logic          too_big;
  logic [31:0]   off;
  logic [63:0]   off64, jj, jk;
  logic          misal, oor;
  logic [HW-1:0] h0;
  logic [IX:0]   lo, hi;
  logic [IX-1:0] idx;
  logic [WORD_BITS-1:0] sel;
  logic [4:0]    fb;
  logic          found;
  logic          word_last;
  logic [HW-1:0] hb, hs;
  logic          pool_wr;

  assign pool_wr = cfg_we_i && (cfg_idx_i == REG_POOL_ORDER);
  assign p_eff   = (32'(pool_q) > MAX_ORDER) ? OW'(MAX_ORDER) : OW'(pool_q);
  assign root    = HW'(64'd1 << (MAX_ORDER - int'(p_eff)));

  always_comb begin
    need    = {1'b0, size_q} + 22'd4;
    too_big = 64'(size_q) > (64'(MIN_BLOCK) << p_q);
    kk      = p_q + OW'(1);
    for (int i = MAX_ORDER; i >= 0; i--) begin
      if ((OW'(i) <= p_q) && ((64'(MIN_BLOCK) << i) >= 64'(need))) kk = OW'(i);
    end
  end

  always_comb begin
    off   = user_q - 32'd4 - base_q;
    off64 = 64'(off);
    misal = (off64 & ((64'd1 << (LOGMB + int'(k_q))) - 64'd1)) != 64'd0;
    oor   = (off64 >> (LOGMB + int'(p_q))) != 64'd0;
    jj    = off64 >> (LOGMB + int'(k_q));
    h0    = HW'((64'd1 << (MAX_ORDER - int'(k_q))) | jj);
    jk    = 64'(h_q) ^ (64'd1 << (MAX_ORDER - int'(k_q)));
  end

  always_comb begin
    lo  = (IX + 1)'(64'd1 << (MAX_ORDER - int'(o_q)));
    hi  = lo + (IX + 1)'(64'd1 << (int'(p_q) - int'(o_q)));
    sel = '0;
    for (int b = 0; b < WORD_BITS; b++) begin
      idx    = {w_q, 5'(b)};
      sel[b] = ram_rdata_i[b] && ({1'b0, idx} >= lo) && ({1'b0, idx} < hi);
    end
    fb = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (sel[b]) fb = 5'(b);
    end
    found     = |sel;
    word_last = w_q == word_of(IX'(hi - (IX + 1)'(1)));
  end

  assign hb = h_q ^ HW'(1);
  assign hs = {h_q[HW-2:0], 1'b1};

  always_comb begin
    p_d          = p_q;
    k_d          = k_q;
    o_d          = o_q;
    bad_d        = bad_q;
    w_d          = w_q;
    h_d          = h_q;
    g_d          = g_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    ram_we_o     = 1'b0;
    ram_waddr_o  = w_q;
    ram_wdata_o  = '0;
    ram_raddr_o  = w_q;
    unique case (op_i)
      OP_NONE: ;
      OP_CLR: begin
        ram_we_o = 1'b1;
        if (w_q == word_of(IX'(root))) ram_wdata_o[root[4:0]] = 1'b1;
        w_d = w_q + AW'(1);
      end
      OP_CAP: p_d = p_eff;
      OP_CALC1: begin
        k_d   = kk;
        bad_d = too_big;
      end
      OP_CALC2: begin
        bad_d = bad_q || (k_q > p_q) || ((opc_q == OPC_FREE) && (misal || oor));
        o_d   = k_q;
        w_d   = word_of(IX'(64'd1 << (MAX_ORDER - int'(k_q))));
        h_d   = h0;
        g_d   = h0;
      end
      OP_RD_W: ram_raddr_o = w_q;
      OP_A_CHK: begin
        if (found) begin
          ram_we_o        = 1'b1;
          ram_wdata_o     = ram_rdata_i;
          ram_wdata_o[fb] = 1'b0;
          h_d             = HW'({w_q, fb});
        end else if (word_last) begin
          o_d = o_q + OW'(1);
          w_d = word_of(IX'(lo >> 1));
        end else begin
          w_d = w_q + AW'(1);
        end
      end
      OP_SP_RD: begin
        ram_raddr_o = word_of(IX'(hs));
        h_d         = {h_q[HW-2:0], 1'b0};
        o_d         = o_q - OW'(1);
      end
      OP_SP_WR: begin
        ram_we_o                 = 1'b1;
        ram_waddr_o              = word_of(IX'(h_q | HW'(1)));
        ram_wdata_o              = ram_rdata_i;
        ram_wdata_o[h_q[4:0] | 5'd1] = 1'b1;
      end
      OP_RD_G: ram_raddr_o = word_of(IX'(g_q));
      OP_F_CHK: begin
        g_d = g_q >> 1;
        o_d = o_q + OW'(1);
      end
      OP_M_INIT: o_d = k_q;
      OP_RD_B: ram_raddr_o = word_of(IX'(hb));
      OP_B_CHK: begin
        if (ram_rdata_i[hb[4:0]]) begin
          ram_we_o              = 1'b1;
          ram_waddr_o           = word_of(IX'(hb));
          ram_wdata_o           = ram_rdata_i;
          ram_wdata_o[hb[4:0]]  = 1'b0;
          h_d                   = h_q >> 1;
          o_d                   = o_q + OW'(1);
        end
      end
      OP_RD_H: ram_raddr_o = word_of(IX'(h_q));
      OP_SET_H: begin
        ram_we_o              = 1'b1;
        ram_waddr_o           = word_of(IX'(h_q));
        ram_wdata_o           = ram_rdata_i;
        ram_wdata_o[h_q[4:0]] = 1'b1;
      end
      OP_OUT_OK: begin
        out_valid_d  = 1'b1;
        out_status_d = 1'b0;
        out_addr_d   = base_q + 32'(jk << (LOGMB + int'(k_q))) + 32'd4;
      end
      OP_OUT_FAIL: begin
        out_valid_d  = 1'b1;
        out_status_d = 1'b1;
        out_addr_d   = '0;
      end
      OP_OUT_FREE: begin
        out_valid_d  = 1'b1;
        out_status_d = 1'b0;
        out_addr_d   = '0;
      end
      default: ;
    endcase
    if (pool_wr) w_d = '0;
  end

  always_comb begin
    stat_o           = '0;
    stat_o.clr_last  = w_q == AW'(NW - 1);
    stat_o.bad       = bad_q;
    stat_o.is_free   = opc_q == OPC_FREE;
    stat_o.found     = found;
    stat_o.word_last = word_last;
    stat_o.o_last    = o_q == p_q;
    stat_o.o_eq_k    = o_q == k_q;
    stat_o.g_bit     = ram_rdata_i[g_q[4:0]];
    stat_o.b_bit     = ram_rdata_i[hb[4:0]];
    stat_o.out_full  = out_valid_q;
    stat_o.pool_wr   = pool_wr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q      <= 4'd10;
      base_q      <= '0;
      w_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && (cfg_idx_i == REG_POOL_ORDER)) pool_q <= cfg_data_i[3:0];
      if (cfg_we_i && (cfg_idx_i == REG_BASE))       base_q <= cfg_data_i;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_CAP) begin
      opc_q  <= opcode_i;
      size_q <= request_size_i;
      user_q <= user_address_i;
    end
    p_q          <= p_d;
    k_q          <= k_d;
    o_q          <= o_d;
    bad_q        <= bad_d;
    h_q          <= h_d;
    g_q          <= g_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = out_status_q;
  assign result_address_o = out_addr_q;

endmodule

// ===== design/buddy_block_allocator.sv =====
// top level of the buddy block allocator
// depends on bba_pkg, bba_ctrl, bba_dp and bba_ram
//
// Binary buddy allocator over 2^pool_order blocks of MIN_BLOCK bytes. One
// request is handled at a time; the free map is one bit per tree node kept
// in 32-bit words of a ram with registered read, and every map access of a
// request is a read followed by a check or write. An accepted request is
// captured, its order is computed and it is checked. An allocate then
// scans map words (orders from the needed one upward, at most
// ceil(2^(pool_order-o)/32) words per order) and splits the found block
// down to the needed order. A free checks each level from the needed order
// up to pool_order, merges with free buddies until a busy buddy or the top
// stops it and marks the final block free; a free that finds an enclosing
// block already free, and a rejected request, end there. A result waits
// while the output register is still full; the controller then returns to
// idle, where the next request is taken. After reset, and after a
// pool_order write while idle, the map is cleared one word a cycle (a
// further pool_order write restarts it), and no request is taken meanwhile.
module buddy_block_allocator
  import bba_pkg::*;
#(
  parameter int unsigned MAX_ORDER = 10,
  parameter int unsigned MIN_BLOCK = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        opcode_i,
  input  logic [20:0] request_size_i,
  input  logic [31:0] user_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [31:0] result_address_o
);

  localparam int unsigned NW = (MAX_ORDER + 1 > 5) ? (1 << (MAX_ORDER - 4)) : 1;
  localparam int unsigned AW = (NW > 1) ? $clog2(NW) : 1;

  op_e                  op;
  stat_t                stat;
  logic                 ready;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  assign in_stall_o = !ready;

  bba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .op_o       (op),
    .ready_o    (ready)
  );

  bba_dp #(
    .MAX_ORDER (MAX_ORDER),
    .MIN_BLOCK (MIN_BLOCK)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .op_i             (op),
    .stat_o           (stat),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .opcode_i         (opcode_i),
    .request_size_i   (request_size_i),
    .user_address_i   (user_address_i),
    .out_stall_i      (out_stall_i),
    .out_valid_o      (out_valid_o),
    .status_o         (status_o),
    .result_address_o (result_address_o),
    .ram_we_o         (ram_we),
    .ram_waddr_o      (ram_waddr),
    .ram_wdata_o      (ram_wdata),
    .ram_raddr_o      (ram_raddr),
    .ram_rdata_i      (ram_rdata)
  );

  bba_ram #(
    .W (WORD_BITS),
    .D (NW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

endmodule
